// ===== hdl/affine_vigenere_letter_cipher_unit_defines.svh =====
// assertion macros shared by the letter cipher rtl
// expects i_clk and the active-low synchronous reset i_rst_n in the using module
`ifndef AFFINE_VIGENERE_LETTER_CIPHER_UNIT_DEFINES_SVH
`define AFFINE_VIGENERE_LETTER_CIPHER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AVLC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("letter cipher check failed");

// consequent must hold in the cycle after the antecedent
`define AVLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("letter cipher check failed");

`endif

// ===== hdl/avlc_pkg.sv =====
// shared types, constants and helper functions of the letter cipher
// no dependencies
package avlc_pkg;

    // key table geometry
    localparam int KEY_MAX   = 64;
    localparam int KEY_AW    = $clog2(KEY_MAX);
    localparam int KEY_IDX_W = 6;
    localparam int KEY_W     = 5;
    localparam int LEN_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int MULT_W    = 5;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 7;
    localparam logic [CFG_AW-1:0] CFG_MULTIPLIER    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_DECRYPT_MODE  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PROGRESS_MODE = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_KEY_LENGTH    = 2'd3;

    // item kinds
    localparam logic FUNC_KEY_LOAD = 1'b0;
    localparam logic FUNC_CIPHER   = 1'b1;

    // alphabet
    localparam logic [KEY_W-1:0]  ALPHA     = 5'd26;
    localparam logic [KEY_W-1:0]  LAST_LTR  = 5'd25;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;

    // key store write port
    typedef struct packed {
        logic               en;
        logic [KEY_AW-1:0]  addr;
        logic [KEY_W-1:0]   data;
    } t_key_wr;

    // (hi * 64) mod 26 for the upper five bits of an 11-bit value
    localparam logic [4:0] HI_MOD [32] = '{
        5'd0,  5'd12, 5'd24, 5'd10, 5'd22, 5'd8,  5'd20, 5'd6,
        5'd18, 5'd4,  5'd16, 5'd2,  5'd14, 5'd0,  5'd12, 5'd24,
        5'd10, 5'd22, 5'd8,  5'd20, 5'd6,  5'd18, 5'd4,  5'd16,
        5'd2,  5'd14, 5'd0,  5'd12, 5'd24, 5'd10, 5'd22, 5'd8
    };

    // inverse multipliers mod 26, zero where none exists and for 1, which inverse_of handles
    localparam logic [4:0] INV_TAB [26] = '{
        5'd0, 5'd0, 5'd0, 5'd9,  5'd0, 5'd21, 5'd0, 5'd15, 5'd0, 5'd3,
        5'd0, 5'd19, 5'd0, 5'd0, 5'd0, 5'd7,  5'd0, 5'd23, 5'd0, 5'd11,
        5'd0, 5'd5, 5'd0, 5'd17, 5'd0, 5'd25
    };

    // ascii letter test
    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    // inverse of the affine multiplier
    function automatic logic [KEY_W-1:0] inverse_of(input logic [MULT_W-1:0] m);
        logic [KEY_W-1:0] r;
        if (m == 5'd1) begin
            r = 5'd1;
        end else if (m < ALPHA) begin
            r = INV_TAB[m];
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // reduce an 11-bit value mod 26: table on the high part, then a small fold
    function automatic logic [KEY_W-1:0] mod26(input logic [10:0] x);
        logic [6:0] s;
        logic [6:0] r;
        s = 7'(HI_MOD[x[10:6]]) + 7'(x[5:0]);
        if (s >= 7'd78) begin
            r = s - 7'd78;
        end else if (s >= 7'd52) begin
            r = s - 7'd52;
        end else if (s >= 7'd26) begin
            r = s - 7'd26;
        end else begin
            r = s;
        end
        return r[KEY_W-1:0];
    endfunction

endpackage

// ===== hdl/avlc_key_store.sv =====
// key table: memory with per-entry valid bits and write-to-read forwarding
// depends on avlc_pkg and the assertion macro header
`include "affine_vigenere_letter_cipher_unit_defines.svh"

module avlc_key_store
    import avlc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [KEY_AW-1:0] i_rd_addr,
    input  t_key_wr           i_wr,
    output logic [KEY_W-1:0]  o_rd_data
);

    logic [KEY_W-1:0]   r_mem [KEY_MAX];
    logic [KEY_MAX-1:0] r_valid;
    logic [KEY_W-1:0]   r_q;
    logic               r_q_vld;
    logic               r_fwd;
    logic [KEY_W-1:0]   r_fwd_data;
    logic               n_fwd;

    // write lands in the same cycle as a read of that entry
    assign n_fwd = i_wr.en && (i_wr.addr == i_rd_addr);

    // memory array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    // valid bits stand in for the all-zero reset of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_vld <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_q_vld <= r_valid[i_rd_addr];
                r_fwd   <= n_fwd;
            end
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
        end
    end

    // forwarded data wins, unwritten entries read as zero
    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_vld ? r_q : '0);

    `AVLC_ASSERT_NEXT(a_wr_marks_valid, i_wr.en, r_valid[$past(i_wr.addr)])
    `AVLC_ASSERT_NEXT(a_fwd_on_hit, i_rd_en && n_fwd, o_rd_data == $past(i_wr.data))
    `AVLC_ASSERT_NEXT(a_plain_read_zero, i_rd_en && !n_fwd && !r_valid[i_rd_addr],
        o_rd_data == '0)

endmodule

// ===== hdl/avlc_cipher_core.sv =====
// affine letter transform of one byte with one shared multiplier
// depends on avlc_pkg
module avlc_cipher_core
    import avlc_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [MULT_W-1:0] i_mult,
    input  logic              i_decrypt,
    output logic              o_letter,
    output logic [CHAR_W-1:0] o_char
);

    logic              lower;
    logic [CHAR_W-1:0] base;
    logic [KEY_W-1:0]  v;
    logic [5:0]        op_a;
    logic [KEY_W-1:0]  op_b;
    logic [10:0]       prod;
    logic [10:0]       sum;
    logic [KEY_W-1:0]  r;
    logic [CHAR_W-1:0] diff;

    // letter class and value
    assign o_letter = is_letter(i_char);
    assign lower    = (i_char >= CH_LO_A);
    assign base     = lower ? CH_LO_A : CH_UP_A;
    assign diff     = i_char - base;
    assign v        = diff[KEY_W-1:0];

    // operands of the one multiplier
    assign op_a = i_decrypt ? (6'(v) + 6'(ALPHA) - 6'(i_key)) : 6'(v);
    assign op_b = i_decrypt ? inverse_of(i_mult) : i_mult;
    assign prod = 11'(op_a) * 11'(op_b);
    assign sum  = prod + (i_decrypt ? 11'd0 : 11'(i_key));
    assign r    = mod26(sum);

    // non-letters pass through
    assign o_char = o_letter ? (base + CHAR_W'(r)) : i_char;

endmodule

// ===== hdl/affine_vigenere_letter_cipher_unit.sv =====
// Affine / Vigenere letter cipher on a byte stream. One item is accepted per
// clock cycle unless a cipher item waits on a stalled output register. The item
// register and the key table's registered read load at the accepting edge; a
// cipher result loads into the output register when its item retires. Key-load
// items (tuser 0) write the table and give no beat out; cipher items (tuser 1)
// give exactly one beat. The key table is cleared at reset by per-entry valid
// bits, so the block is ready right after reset.
// Configuration is to be written only while the stream is idle, a rule on the user that the block leaves unchecked.
// depends on avlc_pkg, avlc_key_store, avlc_cipher_core and the macro header
`include "affine_vigenere_letter_cipher_unit_defines.svh"

module affine_vigenere_letter_cipher_unit
    import avlc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // key_index[5:0], key_value[10:6], char_in[18:11]
    input  logic [0:0]        s_axis_tuser,   // func[0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // char_out[7:0]
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEY_MAX);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // configuration registers
    logic [MULT_W-1:0] r_mult;
    logic              r_dec;
    logic              r_prog;
    logic [LEN_W-1:0]  r_klen;

    // input fields
    logic                 in_func;
    logic [KEY_IDX_W-1:0] in_kidx;
    logic [KEY_W-1:0]     in_kval;
    logic [CHAR_W-1:0]    in_char;
    logic                 in_letter;
    logic                 s_acc;

    // key position
    logic [KEY_AW-1:0] r_pos;
    logic [LEN_W-1:0]  len_eff;
    logic [KEY_AW-1:0] pos_eff;
    logic [LEN_W-1:0]  pos_inc;
    logic [KEY_AW-1:0] n_pos;

    // item register
    logic                 r_s_vld;
    logic                 r_s_func;
    logic [KEY_IDX_W-1:0] r_s_kidx;
    logic [KEY_W-1:0]     r_s_kval;
    logic [CHAR_W-1:0]    r_s_char;
    logic [KEY_AW-1:0]    r_s_pos;
    logic                 s_ret;
    logic                 out_free;

    // datapath
    logic [KEY_W-1:0]  key;
    logic              core_letter;
    logic [CHAR_W-1:0] core_char;
    t_key_wr           key_wr;
    logic [KEY_W-1:0]  kval_red;
    logic              kidx_ok;

    // result register
    logic              r_out_vld;
    logic [CHAR_W-1:0] r_out_data;

    assign in_func   = s_axis_tuser[0];
    assign in_kidx   = s_axis_tdata[5:0];
    assign in_kval   = s_axis_tdata[10:6];
    assign in_char   = s_axis_tdata[18:11];
    assign in_letter = is_letter(in_char);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= 5'd1;
            r_dec  <= 1'b0;
            r_prog <= 1'b0;
            r_klen <= LEN_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MULTIPLIER:    r_mult <= i_cfg_wdata[MULT_W-1:0];
                CFG_DECRYPT_MODE:  r_dec  <= i_cfg_wdata[0];
                CFG_PROGRESS_MODE: r_prog <= i_cfg_wdata[0];
                CFG_KEY_LENGTH:    r_klen <= i_cfg_wdata[LEN_W-1:0];
                default:           r_mult <= r_mult;
            endcase
        end
    end

    // handshake: a cipher item retires into a free result register, a key load retires at once
    assign out_free      = !r_out_vld || m_axis_tready;
    assign s_ret         = r_s_vld && ((r_s_func == FUNC_KEY_LOAD) || out_free);
    assign s_axis_tready = !r_s_vld || s_ret;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // effective key length and position
    always_comb begin
        if (r_klen == '0) begin
            len_eff = LEN_ONE;
        end else if (r_klen > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = r_klen;
        end
        pos_eff = (LEN_W'(r_pos) >= len_eff) ? '0 : r_pos;
        pos_inc = LEN_W'(pos_eff) + LEN_ONE;
        n_pos   = (pos_inc >= len_eff) ? '0 : pos_inc[KEY_AW-1:0];
    end

    // position advances on each accepted cipher letter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (s_acc && (in_func == FUNC_CIPHER) && in_letter) begin
            r_pos <= n_pos;
        end
    end

    // item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (s_acc) begin
            r_s_vld <= 1'b1;
        end else if (s_ret) begin
            r_s_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s_func <= in_func;
            r_s_kidx <= in_kidx;
            r_s_kval <= in_kval;
            r_s_char <= in_char;
            r_s_pos  <= pos_eff;
        end
    end

    avlc_key_store u_key_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_acc),
        .i_rd_addr (pos_eff),
        .i_wr      (key_wr),
        .o_rd_data (key)
    );

    avlc_cipher_core u_cipher_core (
        .i_char    (r_s_char),
        .i_key     (key),
        .i_mult    (r_mult),
        .i_decrypt (r_dec),
        .o_letter  (core_letter),
        .o_char    (core_char)
    );

    // key table write: a key load, or the progress step of a used entry
    assign kval_red = (r_s_kval >= ALPHA) ? (r_s_kval - ALPHA) : r_s_kval;
    assign kidx_ok  = ((KEY_IDX_W + 1)'(r_s_kidx) < (KEY_IDX_W + 1)'(KEY_MAX));

    always_comb begin
        key_wr = '0;
        if (s_ret) begin
            if (r_s_func == FUNC_KEY_LOAD) begin
                key_wr.en   = kidx_ok;
                key_wr.addr = r_s_kidx[KEY_AW-1:0];
                key_wr.data = kval_red;
            end else begin
                key_wr.en   = core_letter && r_prog;
                key_wr.addr = r_s_pos;
                key_wr.data = (key == LAST_LTR) ? '0 : (key + KEY_W'(1));
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_ret && (r_s_func == FUNC_CIPHER)) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ret && (r_s_func == FUNC_CIPHER)) begin
            r_out_data <= core_char;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    `AVLC_ASSERT_NEXT(a_result_loaded, s_ret && (r_s_func == FUNC_CIPHER), m_axis_tvalid)
    `AVLC_ASSERT_NOW(a_stall_cause, !s_axis_tready,
        r_s_vld && (r_s_func == FUNC_CIPHER) && r_out_vld && !m_axis_tready)
    `AVLC_ASSERT_NEXT(a_pos_single,
        s_acc && (in_func == FUNC_CIPHER) && in_letter && (len_eff == LEN_ONE), r_pos == '0)

endmodule
